// ----- rtl/core/gradient_map_three_stop_macros.svh -----
// Assertion macros used by the gradient map port checker.
`ifndef GRADIENT_MAP_THREE_STOP_MACROS_SVH
`define GRADIENT_MAP_THREE_STOP_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define GMTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define GMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/gmts_pkg.sv -----
// Shared types, constants and ramp table of the three-stop gradient map.
package gmts_pkg;

	// Channel code width and full-scale code
	localparam int CHAN_BITS = 8;
	localparam int CHAN_MAX  = (1 << CHAN_BITS) - 1;

	// Register widths
	localparam int PRESET_W = 3;
	localparam int STOP_W   = 24;
	localparam int GAIN_W   = 10;
	localparam int MIX_W    = 9;
	localparam int WEIGHT_W = 24;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 24;

	// Luma scaling: full scale is CHAN_MAX * 2^16, mid-grey half of it
	localparam int FULL_SCALE = CHAN_MAX * 65536;
	localparam int HALF_SCALE = CHAN_MAX * 32768;
	localparam int MID_CODE   = CHAN_MAX * 128;
	localparam int LUM_W      = 24;
	localparam int POS_W      = 24;
	// Quotient limit before the final divide by CHAN_MAX saturates
	localparam int DIV_CLAMP  = CHAN_MAX * CHAN_MAX;

	localparam int ROM_RAMPS = 6;
	localparam int RAMP_LEN  = 9;

	// Register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_PRESET    = 3'd0,
		REG_SHADOW    = 3'd1,
		REG_MID       = 3'd2,
		REG_HIGHLIGHT = 3'd3,
		REG_GAIN      = 3'd4,
		REG_MIX       = 3'd5,
		REG_WEIGHTS   = 3'd6
	} reg_idx_t;

	// Stop selectors
	typedef enum logic [1:0] {
		STOP_SHADOW    = 2'd0,
		STOP_MID       = 2'd1,
		STOP_HIGHLIGHT = 2'd2
	} stop_sel_t;

	typedef struct packed {
		logic [PRESET_W-1:0] preset;
		logic [STOP_W-1:0]   shadow;
		logic [STOP_W-1:0]   mid;
		logic [STOP_W-1:0]   highlight;
		logic [GAIN_W-1:0]   gain;
		logic [MIX_W-1:0]    mix;
		logic [WEIGHT_W-1:0] weights;
	} cfg_t;

	// Load enables of the lane stages
	typedef struct packed {
		logic s5;
		logic s6;
		logic s7;
		logic s8;
	} lane_en_t;

	typedef logic [CHAN_BITS-1:0] ramp_row_t [RAMP_LEN];
	typedef ramp_row_t ramp_rom_t [ROM_RAMPS];

	// Built-in ramps: shadow r,g,b, mid r,g,b, highlight r,g,b
	localparam ramp_rom_t RAMP_ROM = '{
		'{8'd20, 8'd10, 8'd50, 8'd200, 8'd70, 8'd180, 8'd120, 8'd240, 8'd245},
		'{8'd30, 8'd10, 8'd40, 8'd220, 8'd90, 8'd60, 8'd255, 8'd225, 8'd120},
		'{8'd0, 8'd8, 8'd0, 8'd20, 8'd130, 8'd40, 8'd170, 8'd255, 8'd150},
		'{8'd5, 8'd15, 8'd40, 8'd60, 8'd150, 8'd210, 8'd230, 8'd245, 8'd255},
		'{8'd10, 8'd0, 8'd0, 8'd200, 8'd50, 8'd10, 8'd255, 8'd230, 8'd120},
		'{8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255}
	};

	// Look up one stop color channel from the ROM or the custom registers
	function automatic logic [CHAN_BITS-1:0] stop_code(cfg_t cfg, stop_sel_t which,
			logic [1:0] chan);
		logic [3:0]        pos;
		logic [STOP_W-1:0] sel;
		logic [CHAN_BITS-1:0] code;
		pos = 4'(which) * 4'd3 + 4'(chan);
		unique case (which)
			STOP_SHADOW: sel = cfg.shadow;
			STOP_MID:    sel = cfg.mid;
			default:     sel = cfg.highlight;
		endcase
		if (cfg.preset < PRESET_W'(ROM_RAMPS)) begin
			code = RAMP_ROM[cfg.preset][pos];
		end else begin
			code = sel[8*chan +: CHAN_BITS];
		end
		return code;
	endfunction

endpackage

// ----- rtl/core/gradient_map_three_stop.sv -----
// Top level of the three-stop gradient map pixel pipeline.
// Usage:
//   Input channel in_valid/in_stall carries one RGBA pixel (in_red .. in_alpha).
//   A pixel is taken at a clock edge with in_valid high and in_stall low.
//   Output channel out_valid/out_stall carries the mapped pixel; out_alpha is
//   the source alpha unchanged. A pixel leaves at an edge with out_valid high
//   and out_stall low.
//   Registers are written through cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write them only while no pixel is in
//   flight.
//   Each pixel passes the eight pipeline stages in order; one pixel per cycle is
//   accepted sustained while out_stall stays low.
//   When out_stall is high the last stage holds its pixel; earlier stages keep
//   filling empty slots, and in_stall rises only when all eight are full.
//   Reset clears all valid bits and loads the register reset values; the
//   first pixel can be taken in the cycle after reset is released.
module gradient_map_three_stop (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [gmts_pkg::CHAN_BITS-1:0] in_red,
	input  logic [gmts_pkg::CHAN_BITS-1:0] in_green,
	input  logic [gmts_pkg::CHAN_BITS-1:0] in_blue,
	input  logic [gmts_pkg::CHAN_BITS-1:0] in_alpha,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gmts_pkg::CHAN_BITS-1:0] out_red,
	output logic [gmts_pkg::CHAN_BITS-1:0] out_green,
	output logic [gmts_pkg::CHAN_BITS-1:0] out_blue,
	output logic [gmts_pkg::CHAN_BITS-1:0] out_alpha,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gmts_pkg::IDX_W-1:0]     cfg_index,
	input  logic [gmts_pkg::DATA_W-1:0]    cfg_data
);
	import gmts_pkg::*;

	localparam int STAGES = 8;

	cfg_t               cfg;
	logic [STAGES-1:0]  vld_q;
	logic [STAGES-1:0]  adv;
	lane_en_t           lane_en;

	logic [7:0]         src_s1 [3];
	logic [7:0]         src_s2 [3];
	logic [7:0]         src_s3 [3];
	logic [7:0]         src_s4 [3];
	logic [15:0]        wprod_s1 [3];
	logic [7:0]         alpha_s1, alpha_s2, alpha_s3, alpha_s4;
	logic [7:0]         alpha_s5, alpha_s6, alpha_s7, alpha_s8;
	logic [17:0]        luma_sum;
	logic signed [18:0] luma_s2;
	logic signed [29:0] contr_s3;
	logic signed [30:0] lum_raw;
	logic [LUM_W-1:0]   lum;
	logic               lower;
	logic [LUM_W-2:0]   ofs;
	logic [POS_W-1:0]   pos_s4;
	logic [7:0]         lo_s4 [3];
	logic [7:0]         hi_s4 [3];
	logic [7:0]         lane_val [3];
	logic [7:0]         in_chan [3];
	stop_sel_t          lo_sel, hi_sel;

	gmts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		adv[STAGES-1] = !vld_q[STAGES-1] || !out_stall;
		for (int i = STAGES - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign in_stall = !adv[0];

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_chan[0] = in_red;
	assign in_chan[1] = in_green;
	assign in_chan[2] = in_blue;

	// Stage 1: weight each channel
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int k = 0; k < 3; k++) begin
				wprod_s1[k] <= 16'(in_chan[k]) * 16'(cfg.weights[8*k +: 8]);
				src_s1[k]   <= in_chan[k];
			end
			alpha_s1 <= in_alpha;
		end
	end

	// Stage 2: sum to luma and center on mid-grey
	assign luma_sum = 18'(wprod_s1[0]) + 18'(wprod_s1[1]) + 18'(wprod_s1[2]);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			luma_s2  <= $signed({1'b0, luma_sum}) - 19'(MID_CODE);
			src_s2   <= src_s1;
			alpha_s2 <= alpha_s1;
		end
	end

	// Stage 3: apply contrast gain
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			contr_s3 <= luma_s2 * $signed({1'b0, cfg.gain});
			src_s3   <= src_s2;
			alpha_s3 <= alpha_s2;
		end
	end

	// Stage 4: clamp luma, pick the ramp half and its stops
	assign lum_raw = 31'(contr_s3) + 31'(HALF_SCALE);

	always_comb begin
		if (lum_raw < 0) begin
			lum = '0;
		end else if (lum_raw > 31'(FULL_SCALE)) begin
			lum = LUM_W'(FULL_SCALE);
		end else begin
			lum = lum_raw[LUM_W-1:0];
		end
		lower  = lum < LUM_W'(HALF_SCALE);
		ofs    = lower ? lum[LUM_W-2:0] : (LUM_W-1)'(lum - LUM_W'(HALF_SCALE));
		lo_sel = lower ? STOP_SHADOW : STOP_MID;
		hi_sel = lower ? STOP_MID : STOP_HIGHLIGHT;
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			pos_s4 <= {ofs, 1'b0};
			for (int k = 0; k < 3; k++) begin
				lo_s4[k] <= stop_code(cfg, lo_sel, 2'(k));
				hi_s4[k] <= stop_code(cfg, hi_sel, 2'(k));
			end
			src_s4   <= src_s3;
			alpha_s4 <= alpha_s3;
		end
	end

	// Stages 5 to 8 run in the color lanes
	assign lane_en = '{s5: adv[4], s6: adv[5], s7: adv[6], s8: adv[7]};

	for (genvar k = 0; k < 3; k++) begin : g_lane
		gmts_lane u_lane (
			.clk     (clk),
			.en      (lane_en),
			.src     (src_s4[k]),
			.lo_stop (lo_s4[k]),
			.hi_stop (hi_s4[k]),
			.pos     (pos_s4),
			.mix     (cfg.mix),
			.val     (lane_val[k])
		);
	end

	// Carry alpha alongside the lanes
	always_ff @(posedge clk) begin
		if (adv[4]) alpha_s5 <= alpha_s4;
		if (adv[5]) alpha_s6 <= alpha_s5;
		if (adv[6]) alpha_s7 <= alpha_s6;
		if (adv[7]) alpha_s8 <= alpha_s7;
	end

	assign out_valid = vld_q[STAGES-1];
	assign out_red   = lane_val[0];
	assign out_green = lane_val[1];
	assign out_blue  = lane_val[2];
	assign out_alpha = alpha_s8;

endmodule

// ----- rtl/core/gmts_cfg.sv -----
// Configuration register file of the gradient map.
module gmts_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [gmts_pkg::IDX_W-1:0]  cfg_index,
	input  logic [gmts_pkg::DATA_W-1:0] cfg_data,
	output gmts_pkg::cfg_t              cfg
);
	import gmts_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx       = reg_idx_t'(cfg_index);
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Decode the index and write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preset    <= '0;
			cfg_q.shadow    <= 24'h320A14;
			cfg_q.mid       <= 24'hB446C8;
			cfg_q.highlight <= 24'hF5F078;
			cfg_q.gain      <= 10'd256;
			cfg_q.mix       <= 9'd256;
			cfg_q.weights   <= 24'h13B736;
		end else if (cfg_valid && cfg_ready) begin
			unique case (idx)
				REG_PRESET:    cfg_q.preset    <= cfg_data[PRESET_W-1:0];
				REG_SHADOW:    cfg_q.shadow    <= cfg_data[STOP_W-1:0];
				REG_MID:       cfg_q.mid       <= cfg_data[STOP_W-1:0];
				REG_HIGHLIGHT: cfg_q.highlight <= cfg_data[STOP_W-1:0];
				REG_GAIN:      cfg_q.gain      <= cfg_data[GAIN_W-1:0];
				REG_MIX:       cfg_q.mix       <= cfg_data[MIX_W-1:0];
				REG_WEIGHTS:   cfg_q.weights   <= cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/gmts_lane.sv -----
// One color lane: ramp interpolation, source mix, rounding and clamp.
module gmts_lane (
	input  logic                           clk,
	input  gmts_pkg::lane_en_t             en,
	input  logic [gmts_pkg::CHAN_BITS-1:0] src,
	input  logic [gmts_pkg::CHAN_BITS-1:0] lo_stop,
	input  logic [gmts_pkg::CHAN_BITS-1:0] hi_stop,
	input  logic [gmts_pkg::POS_W-1:0]     pos,
	input  logic [gmts_pkg::MIX_W-1:0]     mix,
	output logic [gmts_pkg::CHAN_BITS-1:0] val
);
	import gmts_pkg::*;

	logic signed [8:0]  diff;
	logic signed [33:0] ramp_s5;
	logic signed [8:0]  off_s5;
	logic [7:0]         src_s5, src_s6, src_s7;
	logic signed [34:0] off_ext;
	logic signed [34:0] blend_s6;
	logic signed [44:0] mixed_s7;
	logic [16:0]        bias;
	logic signed [45:0] rnd;
	logic [20:0]        quo_hi;
	logic [15:0]        quo_lo;
	logic [15:0]        div_sum;
	logic [7:0]         val_s8;

	assign diff = $signed({1'b0, hi_stop}) - $signed({1'b0, lo_stop});

	// Scale the stop step by the ramp position, take the stop-to-source offset
	always_ff @(posedge clk) begin
		if (en.s5) begin
			ramp_s5 <= diff * $signed({1'b0, pos});
			off_s5  <= $signed({1'b0, lo_stop}) - $signed({1'b0, src});
			src_s5  <= src;
		end
	end

	// Ramp color minus source, both in full-scale units
	assign off_ext = 35'(off_s5);

	always_ff @(posedge clk) begin
		if (en.s6) begin
			blend_s6 <= (off_ext <<< 24) - (off_ext <<< 16) + 35'(ramp_s5);
			src_s6   <= src_s5;
		end
	end

	// Weight the difference by the mix amount
	always_ff @(posedge clk) begin
		if (en.s7) begin
			mixed_s7 <= blend_s6 * $signed({1'b0, mix});
			src_s7   <= src_s6;
		end
	end

	// Add source and half an LSB, divide by CHAN_MAX * 2^24, clamp
	assign bias    = 17'(src_s7) * 17'd510 + 17'd255;
	assign rnd     = 46'(mixed_s7) + $signed({6'd0, bias, 23'd0});
	assign quo_hi  = rnd[44:24];
	assign quo_lo  = rnd[39:24];
	assign div_sum = quo_lo + 16'(quo_lo >> 8) + 16'd1;

	always_ff @(posedge clk) begin
		if (en.s8) begin
			if (rnd[45]) begin
				val_s8 <= '0;
			end else if (quo_hi >= 21'(DIV_CLAMP)) begin
				val_s8 <= 8'(CHAN_MAX);
			end else begin
				val_s8 <= div_sum[15:8];
			end
		end
	end

	assign val = val_s8;

endmodule

// ----- rtl/core/gmts_checker.sv -----
// Port-level checker for the gradient map, bound to the top level.
`include "gradient_map_three_stop_macros.svh"

module gmts_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [7:0] out_alpha,
	input logic       cfg_ready
);

	logic        out_held;
	logic [31:0] out_pix;

	assign out_held = out_valid && out_stall;
	assign out_pix  = {out_red, out_green, out_blue, out_alpha};

	// Hold a stalled item
	`GMTS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, out_valid, "stalled item dropped")
	`GMTS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_held, $stable(out_pix), "stalled item changed")
	// Stall the input only when the output holds a stalled item
	`GMTS_ASSERT_NOW(a_in_stall_cause, clk, arst_n, in_stall, out_held, "stall with output free")
	// Take register writes at any time
	`GMTS_ASSERT_NOW(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready, "configuration port not ready")

endmodule

bind gradient_map_three_stop gmts_port_checker u_gmts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_red   (out_red),
	.out_green (out_green),
	.out_blue  (out_blue),
	.out_alpha (out_alpha),
	.cfg_ready (cfg_ready)
);

// ----- verif/gmts_checker.sv -----
// Scoreboard for the gradient map: predicts every mapped pixel and compares results.
module gmts_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [gmts_pkg::CHAN_BITS-1:0] in_red,
	input  logic [gmts_pkg::CHAN_BITS-1:0] in_green,
	input  logic [gmts_pkg::CHAN_BITS-1:0] in_blue,
	input  logic [gmts_pkg::CHAN_BITS-1:0] in_alpha,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [gmts_pkg::CHAN_BITS-1:0] out_red,
	input  logic [gmts_pkg::CHAN_BITS-1:0] out_green,
	input  logic [gmts_pkg::CHAN_BITS-1:0] out_blue,
	input  logic [gmts_pkg::CHAN_BITS-1:0] out_alpha,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [gmts_pkg::IDX_W-1:0]     cfg_index,
	input  logic [gmts_pkg::DATA_W-1:0]    cfg_data,
	output int                             errors,
	output int                             pending,
	output int                             checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import gmts_pkg::*;

	localparam longint CODE_MAX  = (longint'(1) << CHAN_BITS) - 1;
	localparam longint LUM_FULL  = CODE_MAX * 65536;
	localparam longint LUM_HALF  = CODE_MAX * 32768;
	localparam longint ROUND_DEN = LUM_FULL * 256;
	localparam int     MAX_PRINTS = 40;

	// Built-in ramps, one row each: shadow r,g,b, mid r,g,b, highlight r,g,b
	localparam logic [0:5][71:0] RAMP_ROWS = {
		{8'd20, 8'd10, 8'd50, 8'd200, 8'd70, 8'd180, 8'd120, 8'd240, 8'd245},
		{8'd30, 8'd10, 8'd40, 8'd220, 8'd90, 8'd60, 8'd255, 8'd225, 8'd120},
		{8'd0, 8'd8, 8'd0, 8'd20, 8'd130, 8'd40, 8'd170, 8'd255, 8'd150},
		{8'd5, 8'd15, 8'd40, 8'd60, 8'd150, 8'd210, 8'd230, 8'd245, 8'd255},
		{8'd10, 8'd0, 8'd0, 8'd200, 8'd50, 8'd10, 8'd255, 8'd230, 8'd120},
		{8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255}
	};

	typedef struct packed {
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
		logic [CHAN_BITS-1:0] alpha;
	} pixel_t;

	cfg_t   live_cfg;
	pixel_t mapped_q [$];
	int     mismatches;
	int     compared;

	// Look up one channel of a stop color, from the ramp table or the custom stops
	function automatic longint stop_level(cfg_t c, stop_sel_t which, int chan);
		logic [STOP_W-1:0]    custom;
		logic [CHAN_BITS-1:0] code;
		longint               lvl;
		int                   slot;
		slot = 3 * int'(which) + chan;
		case (which)
			STOP_SHADOW: custom = c.shadow;
			STOP_MID:    custom = c.mid;
			default:     custom = c.highlight;
		endcase
		if (c.preset < ROM_RAMPS) begin
			code = RAMP_ROWS[c.preset][8 * (8 - slot) +: 8];
		end else begin
			code = custom[8 * chan +: 8];
		end
		lvl = code;
		return lvl;
	endfunction

	// Map one source pixel through the ramp under the given register set
	function automatic pixel_t map_pixel(cfg_t c, pixel_t src);
		longint               chan [3];
		longint               wr, wg, wb, gain, mix, y, lum, u, s0, s1, o, num, rnd, v;
		logic [CHAN_BITS-1:0] mapped [3];
		stop_sel_t            lo_sel, hi_sel;
		pixel_t               res;
		int                   k;
		chan[0] = src.red;
		chan[1] = src.green;
		chan[2] = src.blue;
		wr = c.weights[7:0];
		wg = c.weights[15:8];
		wb = c.weights[23:16];
		gain = c.gain;
		mix = c.mix;
		// luma, contrast about mid-grey, clamp to full scale
		y = wr * chan[0] + wg * chan[1] + wb * chan[2];
		lum = LUM_HALF + (y - CODE_MAX * 128) * gain;
		if (lum < 0) lum = 0;
		if (lum > LUM_FULL) lum = LUM_FULL;
		// lower half runs shadow to mid, mid-grey and up runs mid to highlight
		if (lum < LUM_HALF) begin
			lo_sel = STOP_SHADOW;
			hi_sel = STOP_MID;
			u = lum;
		end else begin
			lo_sel = STOP_MID;
			hi_sel = STOP_HIGHLIGHT;
			u = lum - LUM_HALF;
		end
		// interpolate, blend over the source, round half up, clamp
		for (k = 0; k < 3; k++) begin
			s0 = stop_level(c, lo_sel, k);
			s1 = stop_level(c, hi_sel, k);
			o = s0 * LUM_FULL + (s1 - s0) * 2 * u;
			num = chan[k] * ROUND_DEN + (o - chan[k] * LUM_FULL) * mix;
			rnd = num + ROUND_DEN / 2;
			v = (rnd < 0) ? 0 : rnd / ROUND_DEN;
			if (v > CODE_MAX) v = CODE_MAX;
			mapped[k] = v[CHAN_BITS-1:0];
		end
		res = {mapped[0], mapped[1], mapped[2], src.alpha};
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [CHAN_BITS-1:0] got,
			logic [CHAN_BITS-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("pixel %0d %s: got %0d expected %0d",
				compared, name, got, want));
		end
	endtask

	// Track register writes, predict accepted items, compare delivered items
	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t got, want;
		if (!arst_n) begin
			live_cfg.preset    = '0;
			live_cfg.shadow    = 24'h320A14;
			live_cfg.mid       = 24'hB446C8;
			live_cfg.highlight = 24'hF5F078;
			live_cfg.gain      = GAIN_W'(256);
			live_cfg.mix       = MIX_W'(256);
			live_cfg.weights   = 24'h13B736;
			mapped_q.delete();
			mismatches = 0;
			compared = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {out_red, out_green, out_blue, out_alpha};
				if (mapped_q.size() == 0) begin
					report_mismatch($sformatf("pixel out with nothing pending: %0d %0d %0d %0d",
						got.red, got.green, got.blue, got.alpha));
				end else begin
					want = mapped_q.pop_front();
					check_field("red", got.red, want.red);
					check_field("green", got.green, want.green);
					check_field("blue", got.blue, want.blue);
					check_field("alpha", got.alpha, want.alpha);
					compared++;
				end
			end
			// predict with the settings in force before any write at this edge
			if (in_valid && !in_stall) begin
				mapped_q.insert(mapped_q.size(),
					map_pixel(live_cfg, {in_red, in_green, in_blue, in_alpha}));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PRESET:    live_cfg.preset    = cfg_data[PRESET_W-1:0];
					REG_SHADOW:    live_cfg.shadow    = cfg_data[STOP_W-1:0];
					REG_MID:       live_cfg.mid       = cfg_data[STOP_W-1:0];
					REG_HIGHLIGHT: live_cfg.highlight = cfg_data[STOP_W-1:0];
					REG_GAIN:      live_cfg.gain      = cfg_data[GAIN_W-1:0];
					REG_MIX:       live_cfg.mix       = cfg_data[MIX_W-1:0];
					REG_WEIGHTS:   live_cfg.weights   = cfg_data[WEIGHT_W-1:0];
					default: ;
				endcase
			end
		end
		errors  <= mismatches;
		checked <= compared;
		pending <= mapped_q.size();
	end

endmodule

// ----- verif/testbench.sv -----
// Top of the gradient map testbench: clock, reset, stimulus, register setup and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gmts_pkg::*;

	localparam int LIMIT_CYCLES    = 200000;
	localparam int IDLE_MAX        = 16;
	localparam int HOLD_CYCLES     = 80;
	localparam int SETTLE_CYCLES   = 16;
	localparam int NUM_REGS        = 7;
	localparam int RAND_PHASES     = 12;
	localparam int ITEMS_PER_PHASE = 58;
	localparam int HOLD_PHASE      = 4;

	localparam logic [IDX_W-1:0]    REG_UNUSED    = 3'd7;
	localparam logic [PRESET_W-1:0] PRESET_VAPOR  = 3'd0;
	localparam logic [PRESET_W-1:0] PRESET_MONO   = 3'd5;
	localparam logic [PRESET_W-1:0] PRESET_CUSTOM = 3'd6;
	localparam logic [PRESET_W-1:0] PRESET_ALIAS  = 3'd7;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic [CHAN_BITS-1:0] in_red    = '0;
	logic [CHAN_BITS-1:0] in_green  = '0;
	logic [CHAN_BITS-1:0] in_blue   = '0;
	logic [CHAN_BITS-1:0] in_alpha  = '0;
	logic                 out_stall = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data  = '0;
	logic                 in_stall;
	logic                 out_valid;
	logic [CHAN_BITS-1:0] out_red;
	logic [CHAN_BITS-1:0] out_green;
	logic [CHAN_BITS-1:0] out_blue;
	logic [CHAN_BITS-1:0] out_alpha;
	logic                 cfg_ready;

	int errors;
	int pending;
	int checked;
	int cycles    = 0;
	int settings  = 1;
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_req  = 1'b0;

	gradient_map_three_stop u_dut (.*);

	gmts_checker u_checker (.*);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Cap the run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d pixels still pending", cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one item after a random gap and hold it until taken
	task automatic send_pixel(input logic [CHAN_BITS-1:0] r, g, b, a);
		int gap;
		gap = $urandom_range(0, send_idle);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_red   <= r;
		in_green <= g;
		in_blue  <= b;
		in_alpha <= a;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Send a random pixel, sometimes a grey one
	task automatic send_random;
		logic [CHAN_BITS-1:0] grey;
		grey = CHAN_BITS'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			send_pixel(grey, grey, grey, CHAN_BITS'($urandom));
		end else begin
			send_pixel(CHAN_BITS'($urandom), CHAN_BITS'($urandom), CHAN_BITS'($urandom),
				CHAN_BITS'($urandom));
		end
	endtask

	// Stop offering and wait until every predicted pixel has come out
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Write all registers, then poke the unused index with junk
	task automatic program_regs(input logic [DATA_W-1:0] preset_v, shadow_v, mid_v,
			highlight_v, gain_v, mix_v, weights_v);
		logic [DATA_W-1:0] vals [NUM_REGS];
		int i;
		vals[REG_PRESET]    = preset_v;
		vals[REG_SHADOW]    = shadow_v;
		vals[REG_MID]       = mid_v;
		vals[REG_HIGHLIGHT] = highlight_v;
		vals[REG_GAIN]      = gain_v;
		vals[REG_MIX]       = mix_v;
		vals[REG_WEIGHTS]   = weights_v;
		for (i = 0; i <= NUM_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (i < NUM_REGS) ? IDX_W'(i) : REG_UNUSED;
			cfg_data  <= (i < NUM_REGS) ? vals[i] : DATA_W'($urandom);
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Output side: stall a random count per item, or one long hold on request
	initial begin : receiver
		int wait_cycles;
		forever begin
			if (hold_req) begin
				wait_cycles = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				wait_cycles = $urandom_range(0, recv_idle);
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		logic [DATA_W-1:0] preset_v, gain_v, mix_v, weights_v;
		int ph, n, wr, wg, wb;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: extremes and alternating bit patterns
		send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
		send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
		send_pixel(8'd128, 8'd128, 8'd128, 8'd128);
		send_pixel(8'd127, 8'd127, 8'd127, 8'd1);
		drain;

		// Preset seven with custom stops; red-only weights hit mid-grey exactly at red 255
		program_regs({21'h1FFFFF, PRESET_ALIAS}, 24'h000000, 24'hFFFFFF, 24'h00FF00,
			24'hFFFD00, 24'h000100, 24'h000080);
		send_pixel(8'd255, 8'd0, 8'd0, 8'h5A);
		send_pixel(8'd254, 8'd255, 8'd255, 8'hA5);
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		drain;

		// Zero gain, mix above full, heavy weights
		program_regs({21'd0, PRESET_CUSTOM}, 24'hFF00FF, 24'h00FF00, 24'h808080,
			24'h000000, 24'h0001FF, 24'hFFFFFF);
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd17, 8'd200, 8'd90, 8'd33);
		send_pixel(8'd240, 8'd3, 8'd128, 8'd77);
		drain;

		// Largest gain, no mix: source passes through
		program_regs({21'd0, PRESET_MONO}, 24'h123456, 24'h654321, 24'hABCDEF,
			24'h0003FF, 24'h000000, 24'h13B736);
		send_pixel(8'd0, 8'd0, 8'd0, 8'd9);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd250);
		send_pixel(8'd127, 8'd128, 8'd127, 8'd128);
		send_pixel(8'd128, 8'd128, 8'd128, 8'd127);
		drain;

		// Lowest gain in range, smallest nonzero mix
		program_regs({21'd0, PRESET_VAPOR}, 24'h320A14, 24'hB446C8, 24'hF5F078,
			24'h000040, 24'h000001, 24'h13B736);
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd100, 8'd150, 8'd200, 8'd60);
		drain;

		// Random settings; presets cycle through all eight codes
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			preset_v = DATA_W'($urandom);
			preset_v[PRESET_W-1:0] = PRESET_W'(ph);
			gain_v = DATA_W'($urandom);
			case ($urandom_range(0, 9))
				0:       gain_v[GAIN_W-1:0] = '0;
				1:       gain_v[GAIN_W-1:0] = '1;
				2:       gain_v[GAIN_W-1:0] = GAIN_W'(64);
				3:       gain_v[GAIN_W-1:0] = GAIN_W'(768);
				default: gain_v[GAIN_W-1:0] = GAIN_W'($urandom_range(64, 768));
			endcase
			mix_v = DATA_W'($urandom);
			case ($urandom_range(0, 7))
				0:       mix_v[MIX_W-1:0] = '0;
				1:       mix_v[MIX_W-1:0] = '1;
				2:       mix_v[MIX_W-1:0] = MIX_W'(256);
				default: mix_v[MIX_W-1:0] = MIX_W'($urandom_range(0, 256));
			endcase
			// weights near unity sum most of the time, otherwise anything
			if ($urandom_range(0, 3) != 0) begin
				wr = $urandom_range(0, 255);
				wg = $urandom_range(0, 255 - wr);
				wb = 256 - wr - wg;
				if (wb > 255) wb = 255;
				weights_v = {8'(wb), 8'(wg), 8'(wr)};
			end else begin
				weights_v = DATA_W'($urandom);
			end
			program_regs(preset_v, DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
				gain_v, mix_v, weights_v);

			// rotate idle patterns, including none at all
			case (ph % 4)
				0: begin send_idle = 0;        recv_idle = 0;        end
				1: begin send_idle = IDLE_MAX; recv_idle = IDLE_MAX; end
				2: begin send_idle = 0;        recv_idle = IDLE_MAX; end
				default: begin send_idle = IDLE_MAX; recv_idle = 0; end
			endcase
			// back up the pipeline: long output hold with the input kept busy
			if (ph == HOLD_PHASE) begin
				send_idle = 0;
				hold_req = 1'b1;
			end

			for (n = 0; n < ITEMS_PER_PHASE; n++) send_random;
			drain;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Summary: %0d pixels checked across %0d register settings", checked, settings);
		$display("  covered ROM ramps, custom stops, gain and mix extremes, output hold");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
